[rtl/ialu_pkg.sv]
package ialu_pkg;

   // Default datapath width
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths on the stream ports
   localparam int ACTION_W    = 4;
   localparam int OPERAND_W   = 32;
   localparam int RESULT_W    = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_FIELDS_W = ACTION_W + 2 * OPERAND_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = RESULT_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_OR  = 4'd0,
      ACT_AND = 4'd1,
      ACT_NOT = 4'd2,
      ACT_ADD = 4'd3,
      ACT_SUB = 4'd4,
      ACT_MUL = 4'd5,
      ACT_DIV = 4'd6,
      ACT_MOD = 4'd7,
      ACT_GCD = 4'd8,
      ACT_LCM = 4'd9
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_DIV0   = 2'd1,
      STAT_NOTPOS = 2'd2,
      STAT_OVF    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS_A,
      ST_ABS_B,
      ST_DIV,
      ST_DIV_END,
      ST_SIGN,
      ST_MUL,
      ST_MUL_END,
      ST_GCD_TWOS,
      ST_GCD_XODD,
      ST_GCD_LOOP,
      ST_GCD_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       start;
      action_type action;
   } ialu_cmd_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      status_type status;
   } ialu_stat_type;

endpackage

[rtl/ialu_addsub.sv]
module ialu_addsub #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   input  logic                  sub,
   output logic [DATA_WIDTH:0]   sum
);
   import ialu_pkg::*;

   logic [DATA_WIDTH-1:0] op_b_eff;

   // Subtract as a plus inverted b plus one; carry out high means no borrow
   assign op_b_eff = sub ? ~op_b : op_b;
   assign sum = {1'b0, op_a} + {1'b0, op_b_eff} + {{DATA_WIDTH{1'b0}}, sub};

endmodule

[rtl/ialu_engine.sv]
module ialu_engine #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ialu_pkg::ialu_cmd_type  cmd,
   input  logic [DATA_WIDTH-1:0]   operand_a,
   input  logic [DATA_WIDTH-1:0]   operand_b,
   input  logic                    out_free,
   output ialu_pkg::ialu_stat_type stat,
   output logic [DATA_WIDTH-1:0]   result
);
   import ialu_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   status_type        status_ff, status_in;
   logic [W-1:0]      x_ff, x_in;
   logic [W-1:0]      y_ff, y_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      a_ff, a_in;
   logic [W-1:0]      b_ff, b_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;

   logic [W-1:0]      add_a, add_b;
   logic              add_sub;
   logic [W:0]        add_sum;
   logic [W-1:0]      rem_sh;
   logic              done;

   ialu_addsub #(.DATA_WIDTH(W)) u_addsub (
      .op_a (add_a),
      .op_b (add_b),
      .sub  (add_sub),
      .sum  (add_sum)
   );

   // Remainder shifted left by one with the next dividend bit
   assign rem_sh = {acc_ff[W-2:0], x_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff    <= act_in;
      status_ff <= status_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      status_in = status_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      add_a     = x_ff;
      add_b     = y_ff;
      add_sub   = 1'b0;
      done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            add_a   = operand_a;
            add_b   = operand_b;
            add_sub = (cmd.action == ACT_SUB);
            if (cmd.start) begin
               act_in    = cmd.action;
               a_in      = operand_a;
               b_in      = operand_b;
               acc_in    = '0;
               cnt_in    = CNT_W'(W);
               status_in = STAT_OK;
               x_in      = operand_a;
               y_in      = operand_b;
               state_in  = ST_FINISH;
               unique case (cmd.action)
                  ACT_OR:  x_in = operand_a | operand_b;
                  ACT_AND: x_in = operand_a & operand_b;
                  ACT_NOT: x_in = (operand_a == '0) ? W'(1) : '0;
                  ACT_ADD, ACT_SUB: x_in = add_sum[W-1:0];
                  ACT_MUL: state_in = ST_MUL;
                  ACT_DIV, ACT_MOD: begin
                     if (operand_b == '0) begin
                        status_in = STAT_DIV0;
                        x_in      = '0;
                     end else begin
                        // quotient takes the sign xor, remainder the dividend's sign
                        neg_in   = (cmd.action == ACT_DIV) ?
                                   (operand_a[W-1] ^ operand_b[W-1]) : operand_a[W-1];
                        state_in = ST_ABS_A;
                     end
                  end
                  ACT_GCD, ACT_LCM: begin
                     if (operand_a[W-1] || operand_b[W-1] ||
                         operand_a == '0 || operand_b == '0) begin
                        status_in = STAT_NOTPOS;
                        x_in      = '0;
                     end else begin
                        cnt_in   = '0;
                        state_in = ST_GCD_TWOS;
                     end
                  end
                  default: x_in = '0;
               endcase
            end
         end

         ST_ABS_A: begin
            add_a   = '0;
            add_b   = x_ff;
            add_sub = 1'b1;
            if (x_ff[W-1]) begin
               x_in = add_sum[W-1:0];
            end
            state_in = ST_ABS_B;
         end

         ST_ABS_B: begin
            add_a   = '0;
            add_b   = y_ff;
            add_sub = 1'b1;
            if (y_ff[W-1]) begin
               y_in = add_sum[W-1:0];
            end
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // restoring step: keep the trial difference when there is no borrow
            add_a   = rem_sh;
            add_b   = y_ff;
            add_sub = 1'b1;
            if (add_sum[W]) begin
               acc_in = add_sum[W-1:0];
               x_in   = {x_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               x_in   = {x_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DIV_END;
            end
         end

         ST_DIV_END: begin
            if (act_ff == ACT_LCM) begin
               // quotient a / g times b
               y_in     = b_ff;
               acc_in   = '0;
               cnt_in   = CNT_W'(W);
               state_in = ST_MUL;
            end else begin
               if (act_ff == ACT_MOD) begin
                  x_in = acc_ff;
               end
               state_in = ST_SIGN;
            end
         end

         ST_SIGN: begin
            add_a   = '0;
            add_b   = x_ff;
            add_sub = 1'b1;
            if (neg_ff) begin
               x_in = add_sum[W-1:0];
            end
            state_in = ST_FINISH;
         end

         ST_MUL: begin
            // shift-add: high half in acc, low half shifts into x
            add_a  = acc_ff;
            add_b  = x_ff[0] ? y_ff : '0;
            acc_in = add_sum[W:1];
            x_in   = {add_sum[0], x_ff[W-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_MUL_END;
            end
         end

         ST_MUL_END: begin
            if (act_ff == ACT_LCM && (acc_ff != '0 || x_ff[W-1])) begin
               status_in = STAT_OVF;
               x_in      = '0;
            end
            state_in = ST_FINISH;
         end

         ST_GCD_TWOS: begin
            if (!(x_ff[0] | y_ff[0])) begin
               x_in   = x_ff >> 1;
               y_in   = y_ff >> 1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_GCD_XODD;
            end
         end

         ST_GCD_XODD: begin
            if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else begin
               state_in = ST_GCD_LOOP;
            end
         end

         ST_GCD_LOOP: begin
            add_a   = y_ff;
            add_b   = x_ff;
            add_sub = 1'b1;
            priority if (y_ff == '0) begin
               state_in = ST_GCD_SHIFT;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!add_sum[W]) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               y_in = add_sum[W-1:0];
            end
         end

         ST_GCD_SHIFT: begin
            if (cnt_ff == '0) begin
               if (act_ff == ACT_LCM) begin
                  y_in     = x_ff;
                  x_in     = a_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_W'(W);
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               x_in   = x_ff << 1;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign stat.idle   = (state_ff == ST_IDLE);
   assign stat.done   = done;
   assign stat.status = status_ff;
   assign result      = x_ff;

`ifndef SYNTHESIS
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && state_ff == ST_IDLE) |=> (state_ff != ST_IDLE))
      else $error("engine stayed idle after a start");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (done && status_ff != STAT_OK) |-> (x_ff == '0))
      else $error("error result not zero");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (acc_ff < y_ff))
      else $error("partial remainder not below divisor");

   a_gcd_x_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD_LOOP) |-> x_ff[0])
      else $error("gcd loop entered with even x");
`endif

endmodule

[rtl/integer_alu_with_gcd_lcm_core.sv]
// Integer ALU with divide, remainder, gcd and lcm.
// Request channel (req_*): one item carries an action code and two signed
// operands; the block drops req_tready while it works on an item and raises
// it again as soon as the result has left the engine.
// Response channel (rsp_*): one item per request, the signed result and a
// status (ok, divide by zero, gcd/lcm operand not positive, lcm overflow).
// A result held in the output register does not block the next request.
// How each action is computed, with W = DATA_WIDTH:
//   or, and, not, add, sub and unused codes: directly on accept
//   mul: shift-add, div and mod: restoring, one bit per cycle
//   gcd: binary gcd, one shift, swap or subtract per cycle
//   lcm: gcd, then divide by the gcd, then shift-add multiply
// All arithmetic goes through one shared W-bit adder/subtractor.
// Operands are taken as their low W bits.
// Reset returns the sequencer to idle and empties the output register.
// While rsp_tready is low a finished result waits in the output register;
// a following item is computed and then held in the engine until it frees.
module integer_alu_with_gcd_lcm_core #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata from bit 0: action[3:0], operand_a[35:4], operand_b[67:36], zero pad
   input  logic [ialu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata from bit 0: result_value[31:0], status[33:32], zero pad
   output logic [ialu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);
   import ialu_pkg::*;

   localparam int W = DATA_WIDTH;

   ialu_cmd_type   cmd;
   ialu_stat_type  stat;
   logic [63:0]    a_ext, b_ext;
   logic [W-1:0]   eng_a, eng_b, eng_result;
   logic [63:0]    res_ext;
   logic           out_free;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_result_ff, rsp_result_in;
   status_type     rsp_status_ff, rsp_status_in;

   // Sign-extend each operand, then take its low W bits; the engine reads them as signed
   assign a_ext = {{32{req_tdata[ACTION_W + OPERAND_W - 1]}},
                   req_tdata[ACTION_W +: OPERAND_W]};
   assign b_ext = {{32{req_tdata[ACTION_W + 2 * OPERAND_W - 1]}},
                   req_tdata[ACTION_W + OPERAND_W +: OPERAND_W]};
   assign eng_a = a_ext[W-1:0];
   assign eng_b = b_ext[W-1:0];

   assign req_tready = stat.idle;
   assign cmd.start  = req_tvalid & stat.idle;
   assign cmd.action = action_type'(req_tdata[ACTION_W-1:0]);

   // The output slot can take a result when empty or being emptied
   assign out_free = !rsp_valid_ff || rsp_tready;

   ialu_engine #(.DATA_WIDTH(W)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .operand_a (eng_a),
      .operand_b (eng_b),
      .out_free  (out_free),
      .stat      (stat),
      .result    (eng_result)
   );

   // Sign-extend the W-bit result to the 32-bit field
   assign res_ext = 64'(signed'(eng_result));

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      if (stat.done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = res_ext[RESULT_W-1:0];
         rsp_status_in = stat.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_status_ff, rsp_result_ff};

`ifndef SYNTHESIS
   a_done_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> out_free)
      else $error("result handed over while the output slot is full");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ialu_pkg::*;

   // Codes past the last defined action; the block must answer them with zero.
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd10;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

   localparam logic [31:0] MIN_INT  = 32'h8000_0000;
   localparam logic [31:0] MAX_INT  = 32'h7FFF_FFFF;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam int RANDOM_ITEMS = 450;
   // Longest item is an lcm: a gcd, then a divide and a multiply.
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      status_type                 status;
   } alu_result_type;

   // One row of the directed table. Where typed is set, value and status are
   // the answer read straight off the operation; otherwise the predictor decides.
   typedef struct packed {
      logic [ACTION_W-1:0]  act;
      logic [OPERAND_W-1:0] a;
      logic [OPERAND_W-1:0] b;
      logic                 typed;
      logic [RESULT_W-1:0]  value;
      status_type           status;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   alu_result_type alu_results_due[$];
   int             errors     = 0;
   int             burst_left = 0;

   stim_row_type directed_rows[25];

   integer_alu_with_gcd_lcm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #4 clock = ~clock;

   // Generous fixed time limit on the whole run.
   initial begin
      #20_000_000;
      $display("integer_alu_with_gcd_lcm_core: mismatch");
      $finish;
   end

   // Work out what the block should return for one item, 32-bit datapath.
   function automatic alu_result_type compute_alu_result(input logic [ACTION_W-1:0] act,
                                                          input logic signed [31:0] a,
                                                          input logic signed [31:0] b);
      longint         sa, sb, ua, ub, q, r, x, y, prod;
      alu_result_type res;
      sa = a;
      sb = b;
      res.value  = '0;
      res.status = STAT_OK;
      case (act)
         ACT_OR:  res.value = a | b;
         ACT_AND: res.value = a & b;
         ACT_NOT: res.value = (a == 0) ? 32'sd1 : 32'sd0;
         ACT_ADD: res.value = a + b;
         ACT_SUB: res.value = a - b;
         ACT_MUL: res.value = a * b;
         ACT_DIV, ACT_MOD: begin
            if (sb == 0) begin
               res.status = STAT_DIV0;
            end else begin
               ua = (sa < 0) ? -sa : sa;
               ub = (sb < 0) ? -sb : sb;
               // Truncating divide; the remainder takes the dividend's sign.
               if (act == ACT_DIV) begin
                  q = ua / ub;
                  res.value = ((sa < 0) != (sb < 0)) ? -q : q;
               end else begin
                  r = ua % ub;
                  res.value = (sa < 0) ? -r : r;
               end
            end
         end
         ACT_GCD, ACT_LCM: begin
            if (sa <= 0 || sb <= 0) begin
               res.status = STAT_NOTPOS;
            end else begin
               // Euclid gives the same divisor as the block's binary method.
               x = sa;
               y = sb;
               while (y != 0) begin
                  r = x % y;
                  x = y;
                  y = r;
               end
               if (act == ACT_GCD) begin
                  res.value = x;
               end else begin
                  prod = (sa / x) * sb;
                  if (prod > longint'(MAX_INT))
                     res.status = STAT_OVF;
                  else
                     res.value = prod;
               end
            end
         end
         default: ;
      endcase
      if (res.status != STAT_OK)
         res.value = '0;
      return res;
   endfunction

   // Mix of extremes, small values and full-range noise.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return MIN_INT;
         2:       return MAX_INT;
         3:       return ALL_ONES;
         4:       return 32'd1;
         5:       return $urandom_range(0, 200) - 100;
         default: return $urandom();
      endcase
   endfunction

   // Offer one item in bursts with random gaps; queue its answer once accepted.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [31:0] a,
                            input logic [31:0] b, input alu_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         // Lower valid only when a real gap follows, never lower and raise at once.
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tdata  <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, b, a, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      alu_results_due.push_back(want);
      burst_left--;
   endtask

   // Receiver: hold each stall pattern for a while, then switch to another.
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(16, 160);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Compare every accepted result with the oldest item still due.
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (alu_results_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, got value %h status %0d",
                     $time, rsp_tdata[31:0], rsp_tdata[33:32]);
            errors++;
         end else begin
            want = alu_results_due.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $display("%0t: result_value expected %h, got %h",
                        $time, want.value, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[33:32] !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_tdata[33:32]);
               errors++;
            end
         end
      end
   end

   initial begin
      int                  i;
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [31:0]         a, b, common;
      alu_result_type      want;

      directed_rows = '{
         // logic ops at the extremes
         '{ACT_OR,  MIN_INT, MAX_INT,  1'b1, ALL_ONES, STAT_OK},
         '{ACT_AND, ALL_ONES, 32'd0,   1'b1, 32'd0,    STAT_OK},
         '{ACT_NOT, 32'd0,   ALL_ONES, 1'b1, 32'd1,    STAT_OK},
         '{ACT_NOT, MIN_INT, ALL_ONES, 1'b1, 32'd0,    STAT_OK},
         // wrap-around add, subtract and multiply
         '{ACT_ADD, MAX_INT, 32'd1,    1'b1, MIN_INT,  STAT_OK},
         '{ACT_SUB, MIN_INT, 32'd1,    1'b1, MAX_INT,  STAT_OK},
         '{ACT_MUL, MIN_INT, ALL_ONES, 1'b1, MIN_INT,  STAT_OK},
         '{ACT_MUL, -32'sd7, 32'd3,    1'b0, 32'd0,    STAT_OK},
         // divide and remainder by zero
         '{ACT_DIV, 32'd5,   32'd0,    1'b1, 32'd0,    STAT_DIV0},
         '{ACT_MOD, MIN_INT, 32'd0,    1'b1, 32'd0,    STAT_DIV0},
         // most negative over minus one
         '{ACT_DIV, MIN_INT, ALL_ONES, 1'b1, MIN_INT,  STAT_OK},
         '{ACT_MOD, MIN_INT, ALL_ONES, 1'b1, 32'd0,    STAT_OK},
         // truncation and remainder signs
         '{ACT_DIV, -32'sd7, 32'd2,    1'b0, 32'd0,    STAT_OK},
         '{ACT_MOD, -32'sd7, 32'd2,    1'b0, 32'd0,    STAT_OK},
         '{ACT_MOD, 32'd7,   -32'sd2,  1'b0, 32'd0,    STAT_OK},
         // gcd and lcm operands that are not positive
         '{ACT_GCD, 32'd0,   32'd5,    1'b1, 32'd0,    STAT_NOTPOS},
         '{ACT_GCD, -32'sd3, 32'd6,    1'b1, 32'd0,    STAT_NOTPOS},
         '{ACT_LCM, 32'd4,   MIN_INT,  1'b1, 32'd0,    STAT_NOTPOS},
         // gcd at the top, and one with many shared twos
         '{ACT_GCD, MAX_INT, MAX_INT,  1'b1, MAX_INT,  STAT_OK},
         '{ACT_GCD, 32'h4000_0000, 32'h0010_0000, 1'b0, 32'd0, STAT_OK},
         // lcm overflow and lcm just in range
         '{ACT_LCM, MAX_INT, MAX_INT - 32'd1, 1'b1, 32'd0, STAT_OVF},
         '{ACT_LCM, 32'd65536, 32'd32768, 1'b0, 32'd0,  STAT_OK},
         '{ACT_LCM, 32'd46341, 32'd46340, 1'b0, 32'd0,  STAT_OK},
         // spare codes answer zero
         '{ACT_SPARE_HI, ALL_ONES, ALL_ONES, 1'b1, 32'd0, STAT_OK},
         '{ACT_SPARE_LO, MAX_INT, MIN_INT,   1'b1, 32'd0, STAT_OK}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            want.value  = directed_rows[i].value;
            want.status = directed_rows[i].status;
         end else begin
            want = compute_alu_result(directed_rows[i].act, directed_rows[i].a,
                                      directed_rows[i].b);
         end
         send_item(directed_rows[i].act, directed_rows[i].a, directed_rows[i].b, want);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         else if (pick < 40)
            act = ($urandom_range(0, 1) == 0) ? ACT_GCD : ACT_LCM;
         else
            act = ACTION_W'($urandom_range(0, 7));
         a = pick_operand();
         b = pick_operand();
         // Most gcd and lcm items get positive operands so the loop runs deep.
         if ((act == ACT_GCD || act == ACT_LCM) && $urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 3) == 0) begin
               a = $urandom() >> 1;
               b = $urandom() >> 1;
               if (a == 0) a = 32'd1;
               if (b == 0) b = 32'd1;
            end else begin
               // Shared factor keeps the divisor interesting and lcm near the edge.
               common = $urandom_range(1, 1 << $urandom_range(0, 14));
               a = common * $urandom_range(1, 1 << $urandom_range(0, 14));
               b = common * $urandom_range(1, 1 << $urandom_range(0, 14));
            end
         end
         send_item(act, a, b, compute_alu_result(act, a, b));
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the longest latency for any stray item.
      while (alu_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (alu_results_due.size() != 0) begin
         $display("%0t: %0d items still due, expected none",
                  $time, alu_results_due.size());
         errors++;
      end

      if (errors == 0)
         $display("integer_alu_with_gcd_lcm_core: match");
      else
         $display("integer_alu_with_gcd_lcm_core: mismatch");
      $finish;
   end

endmodule
